>>> rtl/ksl_pkg.sv
// shared constants and types for the short/long key press detector
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ksl_pkg;

  localparam int LEVEL_BITS   = 4;
  localparam int NUM_KEYS_DEF = 4;
  localparam int TIME_W       = 32;
  localparam int THRESH_W     = 16;
  localparam int MASK_W       = 4;
  localparam int KEY_IDX_W    = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [THRESH_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [MASK_W-1:0]   LONG_MASK_RST  = 4'd12;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_CODE_MASK = 1'b1;

  typedef struct packed {
    logic hit;
    logic is_long;
  } lane_evt_t;

endpackage

`default_nettype wire

>>> rtl/ksl_lane.sv
// one key lane: press/release/long tracking state and event decision
// depends on ksl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ksl_lane (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic                           level,
  input  wire logic [ksl_pkg::TIME_W-1:0]     now_ms,
  input  wire logic [ksl_pkg::THRESH_W-1:0]   long_press_ms,
  input  wire logic                           long_code,
  output ksl_pkg::lane_evt_t                  evt
);

  logic                       released_r, released_nxt;
  logic                       done_r, done_nxt;
  logic [ksl_pkg::TIME_W-1:0] start_r, start_nxt;
  logic [ksl_pkg::TIME_W-1:0] elapsed;
  logic                       press, rel, hold;

  assign elapsed = now_ms - start_r;
  assign press   = !level && released_r;
  assign rel     = level && !released_r;
  assign hold    = !level && !released_r && !done_r &&
                   (elapsed > {{(ksl_pkg::TIME_W-ksl_pkg::THRESH_W){1'b0}}, long_press_ms});

  assign evt.hit     = (rel && !done_r) || hold;
  assign evt.is_long = hold && long_code;

  always_comb begin
    released_nxt = released_r;
    done_nxt     = done_r;
    start_nxt    = start_r;
    if (accept) begin
      if (press) begin
        released_nxt = 1'b0;
        done_nxt     = 1'b0;
        start_nxt    = now_ms;
      end else if (rel) begin
        released_nxt = 1'b1;
      end else if (hold) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      released_r <= 1'b1;
      done_r     <= 1'b0;
      start_r    <= '0;
    end else begin
      released_r <= released_nxt;
      done_r     <= done_nxt;
      start_r    <= start_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ksl_merge.sv
// merging stage: holds lane events of up to two polls, each sent in key order
// depends on ksl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ksl_merge #(
  parameter int LANES = ksl_pkg::NUM_KEYS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_accept,
  input  wire ksl_pkg::lane_evt_t [LANES-1:0]   lane_evt,
  output logic                                  in_ready,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ksl_pkg::KEY_IDX_W-1:0]         out_key_index,
  output logic                                  out_is_long,
  output logic                                  out_last_event
);

  logic             a_full_r, a_full_nxt;
  logic [LANES-1:0] a_hit_r, a_hit_nxt;
  logic [LANES-1:0] a_long_r, a_long_nxt;
  logic [LANES-1:0] p_hit_r, p_hit_nxt;
  logic [LANES-1:0] p_long_r, p_long_nxt;
  logic [LANES-1:0] p_rest;
  logic             one_left, pop, p_free, a_move;
  logic [ksl_pkg::KEY_IDX_W-1:0] first_idx;

  // lowest pending key goes first
  always_comb begin
    first_idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (p_hit_r[i]) begin
        first_idx = ksl_pkg::KEY_IDX_W'(i);
      end
    end
  end

  assign p_rest   = p_hit_r & (p_hit_r - LANES'(1));
  assign one_left = (p_rest == '0);
  assign out_valid      = (p_hit_r != '0);
  assign out_key_index  = first_idx;
  assign out_is_long    = p_long_r[first_idx[$clog2(LANES > 1 ? LANES : 2)-1:0]];
  assign out_last_event = one_left;

  assign pop      = out_valid && out_ready;
  assign p_free   = !out_valid || (pop && one_left);
  assign a_move   = a_full_r && p_free;
  assign in_ready = !a_full_r || a_move;

  always_comb begin
    p_hit_nxt  = p_hit_r;
    p_long_nxt = p_long_r;
    a_full_nxt = a_full_r;
    a_hit_nxt  = a_hit_r;
    a_long_nxt = a_long_r;
    if (pop) begin
      p_hit_nxt = p_rest;
    end
    if (a_move) begin
      p_hit_nxt  = a_hit_r;
      p_long_nxt = a_long_r;
      a_full_nxt = 1'b0;
    end
    if (in_accept) begin
      a_full_nxt = 1'b1;
      for (int i = 0; i < LANES; i++) begin
        a_hit_nxt[i]  = lane_evt[i].hit;
        a_long_nxt[i] = lane_evt[i].is_long;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_full_r <= 1'b0;
      p_hit_r  <= '0;
    end else begin
      a_full_r <= a_full_nxt;
      p_hit_r  <= p_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_hit_r  <= a_hit_nxt;
    a_long_r <= a_long_nxt;
    p_long_r <= p_long_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/key_short_long_press_detector_core.sv
// channel  | direction | handshake        | payload
// in_      | request in| in_valid/ready   | key_levels, now_ms
// out_     | event out | out_valid/ready  | key_index, is_long, last_event
// cfg_     | write in  | cfg_we           | cfg_index, cfg_wdata
//
// a poll is taken when in_valid and in_ready are high; its events leave one per
// cycle while out_ready is high, via the accept buffer and the pending register
// polls of at most one event are taken one per cycle while the output keeps up
// reset is synchronous, active low, and releases all keys
// output stall holds the current event; one poll waits in the merge buffer
// top level: per-key lanes and the merging stage; depends on ksl_pkg,
// ksl_lane and ksl_merge
`timescale 1ns / 1ps
`default_nettype none

module key_short_long_press_detector_core #(
  parameter int NUM_KEYS = ksl_pkg::NUM_KEYS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ksl_pkg::LEVEL_BITS-1:0]    in_key_levels,
  input  wire logic [ksl_pkg::TIME_W-1:0]        in_now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ksl_pkg::KEY_IDX_W-1:0]          out_key_index,
  output logic                                   out_is_long,
  output logic                                   out_last_event,
  input  wire logic                              cfg_we,
  input  wire logic [ksl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ksl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // keys without an input bit never leave the released state
  localparam int LANES = (NUM_KEYS < ksl_pkg::LEVEL_BITS) ? NUM_KEYS : ksl_pkg::LEVEL_BITS;

  logic [ksl_pkg::THRESH_W-1:0] long_press_ms_r;
  logic [ksl_pkg::MASK_W-1:0]   long_code_mask_r;
  logic                         in_accept;
  ksl_pkg::lane_evt_t [LANES-1:0] lane_evt;

  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ms_r  <= ksl_pkg::LONG_PRESS_RST;
      long_code_mask_r <= ksl_pkg::LONG_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ksl_pkg::REG_LONG_PRESS_MS:  long_press_ms_r  <= cfg_wdata[ksl_pkg::THRESH_W-1:0];
        ksl_pkg::REG_LONG_CODE_MASK: long_code_mask_r <= cfg_wdata[ksl_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ksl_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .accept        (in_accept),
      .level         (in_key_levels[g]),
      .now_ms        (in_now_ms),
      .long_press_ms (long_press_ms_r),
      .long_code     (long_code_mask_r[g]),
      .evt           (lane_evt[g])
    );
  end

  ksl_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .lane_evt       (lane_evt),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_index  (out_key_index),
    .out_is_long    (out_is_long),
    .out_last_event (out_last_event)
  );

endmodule

`default_nettype wire

>>> rtl/ksl_checker.sv
// port-level checks for the key press detector core, bound to the top level
// depends on ksl_pkg and key_short_long_press_detector_core
`timescale 1ns / 1ps
`default_nettype none

module ksl_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic [ksl_pkg::LEVEL_BITS-1:0]    in_key_levels,
  input  wire logic [ksl_pkg::TIME_W-1:0]        in_now_ms,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [ksl_pkg::KEY_IDX_W-1:0]     out_key_index,
  input  wire logic                              out_is_long,
  input  wire logic                              out_last_event
);

  // waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_key_levels) &&
      $stable(in_now_ms))
    else $error("waiting request changed");

  // stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_index) &&
      $stable(out_is_long) && $stable(out_last_event))
    else $error("stalled event changed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event after reset");

  // the rest of one poll follows without a gap
  a_poll_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_event |=> out_valid)
    else $error("gap inside a poll");

  // events of one poll come in rising key order
  a_key_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_event |=> out_key_index > $past(out_key_index))
    else $error("key order broken inside a poll");

endmodule

bind key_short_long_press_detector_core ksl_checker u_ksl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_key_levels  (in_key_levels),
  .in_now_ms      (in_now_ms),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_key_index  (out_key_index),
  .out_is_long    (out_is_long),
  .out_last_event (out_last_event)
);

`default_nettype wire
